// ===== hdl/olk_pkg.sv =====
// shared types, widths and codes for the ordered list with key removal
package olk_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int ENTRY_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_APPEND = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [ENTRY_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] head_value;
    } rsp_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// ===== hdl/olk_ram.sv =====
// generic simple dual-port ram with registered read
module olk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/olk_front.sv =====
// front end: accepts request beats and classifies them into commands
module olk_front
    import olk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    cmd_t hold_next;
    op_t  op_dec;

    always_comb
    begin
        unique case (req.action)
            ACT_APPEND: op_dec = OP_APPEND;
            ACT_POP:    op_dec = OP_POP;
            ACT_REMOVE: op_dec = OP_REMOVE;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign req_ready = !hold_valid_reg || cmd_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (hold_valid_reg && cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (req_valid && req_ready)
        begin
            hold_valid_next = 1'b1;
            hold_next       = '{op: op_dec, value: req.value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== hdl/olk_queue.sv =====
// short command queue between front end and back end
module olk_queue
    import olk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/olk_back.sv =====
// back end: executes list commands against the node store
module olk_back
    import olk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ALLOC  = 6'b000010,
        S_APPEND = 6'b000100,
        S_LINK   = 6'b001000,
        S_WALK   = 6'b010000,
        S_HEADRD = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      pop_reg, pop_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [IDX_W-1:0]          prv_reg, prv_next;
    logic [CNT_W-1:0]          steps_reg, steps_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic signed [VALUE_W-1:0] hv_reg, hv_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          fresh_reg, fresh_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    // node store ports
    logic                      node_re;
    logic [IDX_W-1:0]          node_raddr;
    logic                      val_we;
    logic [IDX_W-1:0]          val_waddr;
    logic [VALUE_W-1:0]        val_wdata;
    logic [VALUE_W-1:0]        val_rdata;
    logic                      nxt_we;
    logic [IDX_W-1:0]          nxt_waddr;
    logic [IDX_W-1:0]          nxt_wdata;
    logic [IDX_W-1:0]          nxt_rdata;
    // free slot stack ports
    logic                      free_we;
    logic [IDX_W-1:0]          free_waddr;
    logic [IDX_W-1:0]          free_wdata;
    logic                      free_re;
    logic [IDX_W-1:0]          free_raddr;
    logic [IDX_W-1:0]          free_rdata;

    logic [CNT_W-1:0]          fill_dec;
    logic [CNT_W-1:0]          steps_inc;
    logic                      match;
    logic                      finish;
    status_t                   fin_status;

    assign fill_dec  = fill_reg - CNT_W'(1);
    assign steps_inc = steps_reg + CNT_W'(1);
    assign match     = pop_reg || (val_rdata == value_reg);
    assign cmd_ready = (state_reg == S_IDLE) && !rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pop_next       = pop_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        prv_next       = prv_reg;
        steps_next     = steps_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        hv_next        = hv_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        fresh_next     = fresh_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        node_re        = 1'b0;
        node_raddr     = nxt_rdata;
        val_we         = 1'b0;
        val_waddr      = slot_reg;
        val_wdata      = value_reg;
        nxt_we         = 1'b0;
        nxt_waddr      = slot_reg;
        nxt_wdata      = head_reg;
        free_we        = 1'b0;
        free_waddr     = fill_reg[IDX_W-1:0];
        free_wdata     = cur_reg;
        free_re        = 1'b0;
        free_raddr     = fill_dec[IDX_W-1:0];
        finish         = 1'b0;
        fin_status     = ST_OK;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    value_next = cmd.value;
                    unique case (cmd.op)
                        OP_APPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                finish     = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else if (fill_reg != '0)
                            begin
                                free_re    = 1'b1;
                                fill_next  = fill_dec;
                                state_next = S_ALLOC;
                            end
                            else
                            begin
                                slot_next  = fresh_reg[IDX_W-1:0];
                                fresh_next = fresh_reg + CNT_W'(1);
                                state_next = S_APPEND;
                            end
                        end
                        OP_POP, OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                finish     = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                pop_next   = (cmd.op == OP_POP);
                                cur_next   = head_reg;
                                prv_next   = tail_reg;
                                steps_next = '0;
                                node_re    = 1'b1;
                                node_raddr = head_reg;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                slot_next  = free_rdata;
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                if (count_reg == '0)
                begin
                    // first node links to itself
                    nxt_wdata  = slot_reg;
                    head_next  = slot_reg;
                    tail_next  = slot_reg;
                    hv_next    = value_reg;
                    count_next = CNT_W'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = tail_reg;
                nxt_wdata  = slot_reg;
                tail_next  = slot_reg;
                count_next = count_reg + CNT_W'(1);
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (match)
                begin
                    free_we    = 1'b1;
                    fill_next  = fill_reg + CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        hv_next    = '0;
                        count_next = '0;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nxt_we     = 1'b1;
                        nxt_waddr  = prv_reg;
                        nxt_wdata  = nxt_rdata;
                        count_next = count_reg - CNT_W'(1);
                        if (cur_reg == tail_reg)
                        begin
                            tail_next = prv_reg;
                        end
                        if (cur_reg == head_reg)
                        begin
                            // new head value comes from the store next cycle
                            head_next  = nxt_rdata;
                            node_re    = 1'b1;
                            state_next = S_HEADRD;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (steps_inc == count_reg)
                begin
                    finish     = 1'b1;
                    fin_status = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    steps_next = steps_inc;
                    prv_next   = cur_reg;
                    cur_next   = nxt_rdata;
                    node_re    = 1'b1;
                end
            end
            S_HEADRD:
            begin
                hv_next    = val_rdata;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{status: fin_status,
                               entry_count: ENTRY_W'(count_next),
                               head_value: hv_next};
        end
    end

    olk_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (val_rdata)
    );

    olk_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (nxt_rdata)
    );

    olk_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            hv_reg        <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            hv_reg        <= hv_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_reg   <= pop_next;
        value_reg <= value_next;
        slot_reg  <= slot_next;
        cur_reg   <= cur_next;
        prv_reg   <= prv_next;
        steps_reg <= steps_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/ordered_list_with_key_removal_top.sv =====
// top level of the circular singly linked list with key removal
// back end path per beat: a full append answers from S_IDLE; other appends pass
//   S_ALLOC when a freed slot is reused, S_APPEND, then S_LINK when the list was not
//   empty; pop and remove by value walk in S_WALK, one node visited per cycle, then
//   pass S_HEADRD when the head goes and nodes remain; one request is in flight in the
//   back end; the walk through the value and link memories sets the worst case
// reset: asynchronous active low; list comes up empty, no clearing pass needed
module ordered_list_with_key_removal_top
    import olk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // front end to queue
    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;

    // queue to back end
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    // request beats are registered and decoded into commands
    olk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // short queue so the front keeps taking beats while the back end walks
    olk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    // back end owns the node store, link store and free slot stack;
    // the backward link of a node is tracked by the walk and the tail register
    olk_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/olk_checker.sv =====
// port-level checker for the list block, bound to the top level
module olk_port_props
    import olk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // stalled response beat stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat dropped or changed while stalled");

    // empty list reports no entries and a zero head
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0)
        && (rsp.head_value == '0))
        else $error("empty status with nonzero count or head");

    // zero entries means a zero head value
    a_count_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.entry_count == '0) |-> (rsp.head_value == '0))
        else $error("empty list with nonzero head value");

    // full status only when the store holds every slot
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> (rsp.entry_count == ENTRY_W'(DEPTH)))
        else $error("full status with store not full");

endmodule

bind ordered_list_with_key_removal_top olk_port_props #(
    .DEPTH (DEPTH)
) u_olk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
